FILE: rtl/bia_pkg.sv
// bitmap index allocator: shared beat types, opcodes, status codes and state encoding
// no dependencies; imported by every module of the block

package bia_pkg;

  localparam int IDX_FIELD_W = 8;
  localparam int LIMIT_REG_W = 9;
  localparam int RESET_LIMIT = 64;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FREE  = 2'd3;

  typedef struct packed {
    logic                   op;
    logic [IDX_FIELD_W-1:0] index;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] index_res;
    logic [1:0]             status;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_WRITE,
    S_HOLD
  } bia_state_t;

endpackage

FILE: rtl/bia_map_mem.sv
// bitmap index allocator: synchronous word memory holding the used bitmap
// one write port, one registered read port; uses bia_pkg

module bia_map_mem
  import bia_pkg::*;
#(
  parameter int DEPTH = 4,
  parameter int WIDTH = 64,
  parameter int AW    = 2
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic             re,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule

FILE: rtl/bia_ffs.sv
// bitmap index allocator: lowest set bit finder over one map word
// combinational; uses bia_pkg

module bia_ffs
  import bia_pkg::*;
#(
  parameter int WIDTH = 64,
  parameter int POS_W = 6
) (
  input  logic [WIDTH-1:0] vec,
  output logic             found,
  output logic [POS_W-1:0] pos
);

  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (vec[i]) begin
        found = 1'b1;
        pos   = POS_W'(i);
      end
    end
  end

endmodule

FILE: rtl/bitmap_index_allocator_core.sv
// bitmap index allocator: top level with sequencer, soft limit logic and output register
// uses bia_pkg, bia_map_mem, bia_ffs
//
//   port group | direction | handshake        | payload
//   in_        | input     | in_valid/in_stall | in_beat_t  (op, index)
//   out_       | output    | out_valid/out_stall | out_beat_t (index_res, status)
//   cfg_       | input     | cfg_we            | initial_limit, 9 bits
//
// after reset a clearing pass writes every map word, input stalled.
// an allocate reads its start word, then reads further words while no free bit is found, and
// writes the chosen word back; the scan reads one word per cycle from the single read port of
// the map memory. a release of a taken index reads, writes back and gives its result, of a free
// index it reads and gives its result; an out of range release gives its result without a read.
// one item is worked at a time; a finished result waits in a hold register while out_stall is
// high, and the next input beat is taken once that result has moved to the output register.

module bitmap_index_allocator_core
  import bia_pkg::*;
#(
  parameter int CAPACITY  = 256,
  parameter int WORD_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_beat_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_beat_t              out_data,
  input  logic                   cfg_we,
  input  logic [LIMIT_REG_W-1:0] cfg_wdata
);

  localparam int NUM_CHUNKS = CAPACITY / WORD_BITS;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int LIM_W      = (CNT_W > LIMIT_REG_W) ? CNT_W : LIMIT_REG_W;
  localparam int CMP_W      = LIM_W + 1;
  localparam int OFF_W      = $clog2(WORD_BITS);
  localparam int WA_W       = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int K_W        = $clog2(NUM_CHUNKS + 1);
  localparam int RECIP_SH   = 16;
  localparam int RECIP      = ((2 ** RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int RECIP_W    = RECIP_SH + 1;
  localparam int PROD_W     = IDX_FIELD_W + RECIP_W;

  localparam logic [CMP_W-1:0] CAP_C     = CMP_W'(CAPACITY);
  localparam logic [WA_W-1:0]  LAST_WORD = WA_W'(NUM_CHUNKS - 1);
  localparam logic [OFF_W-1:0] LAST_OFF  = OFF_W'(WORD_BITS - 1);

  bia_state_t state_r, state_nxt;

  logic [LIM_W-1:0]      soft_r;
  logic [IDX_W-1:0]      last_r;
  logic [WA_W-1:0]       last_word_r;
  logic [OFF_W-1:0]      last_off_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [WA_W-1:0]       clr_ptr_r;
  logic [K_W-1:0]        k_r;
  logic                  out_vld_r;
  out_beat_t             out_r;

  logic                  op_r;
  logic [IDX_FIELD_W-1:0] idx_r;
  logic [WA_W-1:0]       ptr_r;
  logic [OFF_W-1:0]      st_off_r;
  logic [OFF_W-1:0]      pick_off_r;
  logic [WORD_BITS-1:0]  wr_data_r;
  out_beat_t             res_r;

  logic                  accept;
  logic                  out_free;
  logic [CMP_W-1:0]      next_lin;
  logic [CMP_W-1:0]      soft_ext;
  logic [CMP_W-1:0]      soft_dbl;
  logic [LIM_W-1:0]      soft_new;
  logic                  grow;
  logic                  zero_start;
  logic [WA_W-1:0]       nx_word;
  logic [OFF_W-1:0]      nx_off;
  logic [PROD_W-1:0]     rel_prod;
  logic [WA_W-1:0]       rel_word;
  logic                  rel_oor;
  logic [CMP_W-1:0]      rel_base;
  logic [OFF_W-1:0]      rel_off;
  logic                  rel_taken;
  logic [WA_W-1:0]       ptr_inc;
  logic                  k_last;
  logic [WORD_BITS-1:0]  rd_data;
  logic [WORD_BITS-1:0]  keep_mask;
  logic [WORD_BITS-1:0]  scan_vec;
  logic                  ffs_found;
  logic [OFF_W-1:0]      ffs_pos;
  logic [CMP_W-1:0]      pick_lin;
  logic [CMP_W-1:0]      cfg_ext;
  logic [LIM_W-1:0]      cfg_limit;

  logic                  rd_en;
  logic [WA_W-1:0]       rd_addr;
  logic                  mem_we;
  logic [WA_W-1:0]       mem_wa;
  logic [WORD_BITS-1:0]  mem_wd;
  logic                  ld_start;
  logic                  adv;
  logic                  take;
  logic                  commit;
  logic                  fin;
  out_beat_t             fin_res;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_vld_r || !out_stall;

  // allocate start point and soft limit growth
  always_comb begin
    next_lin   = CMP_W'(last_r) + CMP_W'(1);
    soft_ext   = CMP_W'(soft_r);
    soft_dbl   = soft_ext << 1;
    grow       = (next_lin >= soft_ext) && (CMP_W'(cnt_r) > (soft_ext >> 1));
    if (grow) begin
      soft_new = (soft_dbl > CAP_C) ? LIM_W'(CAP_C) : LIM_W'(soft_dbl);
    end else begin
      soft_new = soft_r;
    end
    zero_start = (next_lin >= CMP_W'(soft_new)) || (next_lin >= CAP_C);
    if (last_off_r == LAST_OFF) begin
      nx_word = last_word_r + WA_W'(1);
      nx_off  = '0;
    end else begin
      nx_word = last_word_r;
      nx_off  = last_off_r + OFF_W'(1);
    end
  end

  // release address split: word by reciprocal multiply, offset after the register
  always_comb begin
    rel_prod  = PROD_W'(in_data.index) * PROD_W'(RECIP);
    rel_word  = WA_W'(rel_prod >> RECIP_SH);
    rel_oor   = CMP_W'(in_data.index) >= CAP_C;
    rel_base  = CMP_W'(ptr_r) * CMP_W'(WORD_BITS);
    rel_off   = OFF_W'(CMP_W'(idx_r) - rel_base);
    rel_taken = rd_data[rel_off];
  end

  always_comb begin
    ptr_inc   = (ptr_r == LAST_WORD) ? '0 : ptr_r + WA_W'(1);
    k_last    = (k_r == K_W'(NUM_CHUNKS));
    keep_mask = (k_r == '0) ? ({WORD_BITS{1'b1}} << st_off_r) : {WORD_BITS{1'b1}};
    scan_vec  = ~rd_data & keep_mask;
    pick_lin  = CMP_W'(ptr_r) * CMP_W'(WORD_BITS) + CMP_W'(pick_off_r);
    cfg_ext   = CMP_W'(cfg_wdata);
    cfg_limit = (cfg_ext > CAP_C) ? LIM_W'(CAP_C) : LIM_W'(cfg_ext);
  end

  bia_ffs #(
    .WIDTH (WORD_BITS),
    .POS_W (OFF_W)
  ) u_ffs (
    .vec   (scan_vec),
    .found (ffs_found),
    .pos   (ffs_pos)
  );

  bia_map_mem #(
    .DEPTH (NUM_CHUNKS),
    .WIDTH (WORD_BITS),
    .AW    (WA_W)
  ) u_map (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd),
    .re  (rd_en),
    .ra  (rd_addr),
    .rd  (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_ptr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_data.op == OP_RELEASE && rel_oor) begin
            state_nxt = out_free ? S_IDLE : S_HOLD;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (op_r == OP_ALLOC) begin
          if (ffs_found) begin
            state_nxt = S_WRITE;
          end else if (k_last) begin
            state_nxt = out_free ? S_IDLE : S_HOLD;
          end
        end else if (rel_taken) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_WRITE: state_nxt = out_free ? S_IDLE : S_HOLD;
      S_HOLD:  state_nxt = out_free ? S_IDLE : S_HOLD;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    rd_addr  = '0;
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_wd   = '0;
    ld_start = 1'b0;
    adv      = 1'b0;
    take     = 1'b0;
    commit   = 1'b0;
    fin      = 1'b0;
    fin_res  = res_r;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_ptr_r;
        mem_wd = (clr_ptr_r == '0) ? WORD_BITS'(1) : '0;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (accept) begin
          ld_start = 1'b1;
          if (in_data.op == OP_RELEASE) begin
            if (rel_oor) begin
              fin               = 1'b1;
              fin_res.index_res = in_data.index;
              fin_res.status    = ST_RANGE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = rel_word;
            end
          end else begin
            rd_en   = 1'b1;
            rd_addr = zero_start ? '0 : nx_word;
          end
        end
      end
      S_CHECK: begin
        if (op_r == OP_ALLOC) begin
          if (ffs_found) begin
            take = 1'b1;
          end else if (k_last) begin
            fin               = 1'b1;
            fin_res.index_res = '0;
            fin_res.status    = ST_FULL;
          end else begin
            adv     = 1'b1;
            rd_en   = 1'b1;
            rd_addr = ptr_inc;
          end
        end else if (rel_taken) begin
          take = 1'b1;
        end else begin
          fin               = 1'b1;
          fin_res.index_res = idx_r;
          fin_res.status    = ST_FREE;
        end
      end
      S_WRITE: begin
        mem_we         = 1'b1;
        mem_wa         = ptr_r;
        mem_wd         = wr_data_r;
        commit         = 1'b1;
        fin            = 1'b1;
        fin_res.status = ST_OK;
        if (op_r == OP_ALLOC) begin
          fin_res.index_res = IDX_FIELD_W'(pick_lin);
        end else begin
          fin_res.index_res = idx_r;
        end
      end
      S_HOLD: begin
        fin = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_ptr_r   <= '0;
      soft_r      <= LIM_W'(RESET_LIMIT);
      last_r      <= '0;
      last_word_r <= '0;
      last_off_r  <= '0;
      cnt_r       <= CNT_W'(1);
      k_r         <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_ptr_r <= clr_ptr_r + WA_W'(1);
      end
      if (ld_start) begin
        k_r <= '0;
        if (in_data.op == OP_ALLOC) begin
          soft_r <= soft_new;
        end
      end
      if (adv) begin
        k_r <= k_r + K_W'(1);
      end
      if (commit) begin
        if (op_r == OP_ALLOC) begin
          last_r      <= IDX_W'(pick_lin);
          last_word_r <= ptr_r;
          last_off_r  <= pick_off_r;
          cnt_r       <= cnt_r + CNT_W'(1);
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
      if (fin && out_free) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_we) begin
        soft_r <= cfg_limit;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ld_start) begin
      op_r  <= in_data.op;
      idx_r <= in_data.index;
      if (in_data.op == OP_ALLOC) begin
        ptr_r    <= zero_start ? '0 : nx_word;
        st_off_r <= zero_start ? '0 : nx_off;
      end else begin
        ptr_r <= rel_word;
      end
    end
    if (adv) begin
      ptr_r <= ptr_inc;
    end
    if (take) begin
      if (op_r == OP_ALLOC) begin
        pick_off_r <= ffs_pos;
        wr_data_r  <= rd_data | (WORD_BITS'(1) << ffs_pos);
      end else begin
        wr_data_r  <= rd_data & ~(WORD_BITS'(1) << rel_off);
      end
    end
    if (fin) begin
      if (out_free) begin
        out_r <= fin_res;
      end else begin
        res_r <= fin_res;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
